// ===== rtl/dtoc_pkg.sv =====
// Shared types and constants of the dual drive turn offset controller.
package dtoc_pkg;

  localparam int GEAR_W     = 16;
  localparam int STEP_W     = 20;
  localparam int PERIOD_W   = 16;
  localparam int FIELD_W    = 32;
  localparam int ANGLE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Q16.16 target = -(angle * gear * 2) / 45, rounded to nearest
  localparam int PROD_W     = ANGLE_W + GEAR_W;
  localparam int DIVISOR    = 45;
  localparam int ROUND_BIAS = 22;
  localparam int REM_W      = 6;
  localparam int DIV_DIGIT  = 8;
  localparam int DIV_STEPS  = 7;
  localparam int DIV_W      = DIV_DIGIT * DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int QUO_W      = 44;
  localparam int TGT_W      = QUO_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEAR_RATIO     = 2'd0,
    CFG_TURN_STEP      = 2'd1,
    CFG_CONTROL_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_UPD  = 7'b0010000,
    ST_CMD  = 7'b0100000,
    ST_PUSH = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0]        time_ms;
    logic signed [ANGLE_W-1:0] continuous_angle;
    logic                      left_brake;
    logic                      right_brake;
    logic                      in_turn_zone;
  } in_t;

  typedef struct packed {
    logic                      control_done;
    logic                      left_enable;
    logic                      right_enable;
    logic                      left_send;
    logic                      right_send;
    logic signed [FIELD_W-1:0] left_target;
    logic signed [FIELD_W-1:0] right_target;
    logic                      turning_now;
  } out_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic div_step;
    logic update;
    logic command;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

// ===== rtl/dtoc_ctrl.sv =====
// Sequencing state machine of the turn offset controller.
module dtoc_ctrl import dtoc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CMD;
      end
      ST_CMD: begin
        cmd.command = 1'b1;
        state_nxt   = ST_PUSH;
      end
      ST_PUSH: begin
        if (!sts.out_blocked) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/dtoc_datapath.sv =====
// Datapath: registers, target scaling, offset updates and result register.
module dtoc_datapath import dtoc_pkg::*; #(
  parameter int POSITION_WIDTH = 32,
  parameter int TIME_WIDTH     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  localparam int PW    = POSITION_WIDTH;
  localparam int TW    = TIME_WIDTH;
  localparam int SUM_W = ((PW > TGT_W) ? PW : TGT_W) + 2;
  localparam logic signed [SUM_W-1:0] POS_MAX = (SUM_W'(1) <<< (PW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  function automatic logic signed [SUM_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > POS_MAX) r = POS_MAX;
    if (v < POS_MIN) r = POS_MIN;
    return r;
  endfunction

  // configuration
  logic [GEAR_W-1:0]   gear_r;
  logic [STEP_W-1:0]   step_r;
  logic [PERIOD_W-1:0] period_r;

  // controller state
  logic signed [PW-1:0] lhold_r, rhold_r, lturn_r, rturn_r;
  logic signed [PW-1:0] lhold_nxt, rhold_nxt, lturn_nxt, rturn_nxt;
  logic                 turning_r, len_r, ren_r;
  logic                 turning_nxt, len_nxt, ren_nxt;
  logic [TW-1:0]        last_r;

  // per-request registers
  logic [ANGLE_W-1:0]       abs_r;
  logic                     neg_r, lb_r, rb_r, zone_r, due_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DIV_W-1:0]         div_r, div_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic signed [TGT_W-1:0]  t_r;
  logic signed [FIELD_W-1:0] lt_r, rt_r;
  logic                     ls_r, rs_r;
  logic                     out_valid_r;
  out_t                     out_data_r;

  logic [TW-1:0]  now, elapsed;
  logic           due;
  logic           both, lone, rone, oneout, none;
  logic [QUO_W:0] quo;
  logic signed [SUM_W-1:0] t_ext, lt_sum, rt_sum, l_add, r_add;
  logic           ls, rs;

  assign now     = in_data.time_ms[TW-1:0];
  assign elapsed = now - last_r;
  assign due     = (elapsed >= TW'(period_r));

  assign both   = lb_r & rb_r;
  assign lone   = lb_r & ~rb_r & zone_r;
  assign rone   = rb_r & ~lb_r & zone_r;
  assign oneout = (lb_r ^ rb_r) & ~zone_r;
  assign none   = ~lb_r & ~rb_r;

  assign sts.out_blocked = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // radix-256 restoring division by 45
  always_comb begin
    logic [DIV_W-1:0] dv;
    logic [REM_W-1:0] rm;
    logic [REM_W:0]   trial;
    dv = div_r;
    rm = rem_r;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial = {rm, dv[DIV_W-1]};
      dv    = {dv[DIV_W-2:0], 1'b0};
      if (trial >= (REM_W + 1)'(DIVISOR)) begin
        rm    = REM_W'(trial - (REM_W + 1)'(DIVISOR));
        dv[0] = 1'b1;
      end else begin
        rm = trial[REM_W-1:0];
      end
    end
    div_nxt = dv;
    rem_nxt = rm;
  end

  assign quo = {1'b0, div_r[QUO_W-1:0]};

  // offset and enable updates
  always_comb begin
    lhold_nxt   = lhold_r;
    rhold_nxt   = rhold_r;
    lturn_nxt   = lturn_r;
    rturn_nxt   = rturn_r;
    turning_nxt = turning_r;
    len_nxt     = len_r;
    ren_nxt     = ren_r;
    if (due_r) begin
      if (both) begin
        len_nxt     = 1'b0;
        ren_nxt     = 1'b0;
        turning_nxt = 1'b1;
      end else if (oneout) begin
        len_nxt = 1'b0;
        ren_nxt = 1'b0;
      end else if (lone) begin
        turning_nxt = 1'b1;
        len_nxt     = 1'b0;
        ren_nxt     = 1'b1;
        rturn_nxt   = PW'(sat_pos(SUM_W'(rturn_r) - signed'(SUM_W'(step_r))));
      end else if (rone) begin
        turning_nxt = 1'b1;
        ren_nxt     = 1'b0;
        len_nxt     = 1'b1;
        lturn_nxt   = PW'(sat_pos(SUM_W'(lturn_r) + signed'(SUM_W'(step_r))));
      end else begin
        if (turning_r) begin
          lhold_nxt   = PW'(sat_pos(SUM_W'(lhold_r) + SUM_W'(lturn_r)));
          rhold_nxt   = PW'(sat_pos(SUM_W'(rhold_r) + SUM_W'(rturn_r)));
          lturn_nxt   = '0;
          rturn_nxt   = '0;
          turning_nxt = 1'b0;
        end
        len_nxt = 1'b1;
        ren_nxt = 1'b1;
      end
    end
  end

  // position commands
  always_comb begin
    t_ext  = SUM_W'(t_r);
    l_add  = rone ? SUM_W'(lturn_r) : signed'(SUM_W'(0));
    r_add  = lone ? SUM_W'(rturn_r) : signed'(SUM_W'(0));
    lt_sum = sat_pos(t_ext + SUM_W'(lhold_r) + l_add);
    rt_sum = sat_pos(SUM_W'(rhold_r) - t_ext + r_add);
    ls     = due_r & (rone | none);
    rs     = due_r & (lone | none);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      abs_r  <= in_data.continuous_angle[ANGLE_W-1] ? ANGLE_W'(-in_data.continuous_angle)
                                                    : ANGLE_W'(in_data.continuous_angle);
      neg_r  <= in_data.continuous_angle[ANGLE_W-1];
      lb_r   <= in_data.left_brake;
      rb_r   <= in_data.right_brake;
      zone_r <= in_data.in_turn_zone;
      due_r  <= due;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(abs_r) * PROD_W'(gear_r);
    end
    if (cmd.load) begin
      div_r <= DIV_W'({prod_r, 1'b0}) + DIV_W'(ROUND_BIAS);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      div_r <= div_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.update) begin
      t_r <= neg_r ? signed'(quo) : -signed'(quo);
    end
    if (cmd.command) begin
      lt_r <= ls ? FIELD_W'(lt_sum) : '0;
      rt_r <= rs ? FIELD_W'(rt_sum) : '0;
      ls_r <= ls;
      rs_r <= rs;
    end
    if (cmd.push) begin
      out_data_r.control_done <= due_r;
      out_data_r.left_enable  <= len_r;
      out_data_r.right_enable <= ren_r;
      out_data_r.left_send    <= ls_r;
      out_data_r.right_send   <= rs_r;
      out_data_r.left_target  <= lt_r;
      out_data_r.right_target <= rt_r;
      out_data_r.turning_now  <= turning_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r      <= GEAR_W'(256);
      step_r      <= STEP_W'(655);
      period_r    <= PERIOD_W'(10);
      lhold_r     <= '0;
      rhold_r     <= '0;
      lturn_r     <= '0;
      rturn_r     <= '0;
      turning_r   <= 1'b0;
      len_r       <= 1'b1;
      ren_r       <= 1'b1;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GEAR_RATIO:     gear_r   <= cfg_wdata[GEAR_W-1:0];
          CFG_TURN_STEP:      step_r   <= cfg_wdata[STEP_W-1:0];
          CFG_CONTROL_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture && due) begin
        last_r <= now;
      end
      if (cmd.update) begin
        lhold_r   <= lhold_nxt;
        rhold_r   <= rhold_nxt;
        lturn_r   <= lturn_nxt;
        rturn_r   <= rturn_nxt;
        turning_r <= turning_nxt;
        len_r     <= len_nxt;
        ren_r     <= ren_nxt;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/dual_drive_turn_offset_controller.sv =====
// Top level of the dual drive turn offset controller.
// One request is in flight at a time. From acceptance until the block is ready again it
// passes through the 32x16 multiply, the divider load, the division by 45 that turns the
// scaled angle into a Q16.16 target (eight quotient bits a cycle), the offset update,
// the position sums and the hand-over to the result register. A result waiting in the
// output register does not hold up acceptance; the block stalls only when a new result
// is ready while the previous one has still not been taken.
module dual_drive_turn_offset_controller import dtoc_pkg::*; #(
  parameter int POSITION_WIDTH = 32,
  parameter int TIME_WIDTH     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  dtoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtoc_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/dtoc_checker.sv =====
// Port-level checks of the turn offset controller and their binding.
module dtoc_checker import dtoc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.control_done |->
      !out_data.left_send && !out_data.right_send &&
      out_data.left_target == '0 && out_data.right_target == '0)
    else $error("command issued without a control action");

  a_send_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (!out_data.left_send || out_data.left_enable) &&
      (!out_data.right_send || out_data.right_enable))
    else $error("command sent to a disabled drive");

  a_mirror_not_turning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.left_send && out_data.right_send |-> !out_data.turning_now)
    else $error("mirror commands while turning");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind dual_drive_turn_offset_controller dtoc_checker u_dtoc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
